@@ rtl/bbc_pkg.sv @@
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W     = 7;
    localparam int DEPTH_SAT   = 127;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ROUND  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_CURLY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_MATCH    = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic               done_res;
        logic               balanced;
        logic [1:0]         status;
        logic [DEPTH_W-1:0] open_depth;
    } t_out;

    function automatic t_kind opener_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            CH_OPEN_ROUND:  k = KIND_ROUND;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            CH_OPEN_CURLY:  k = KIND_CURLY;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic t_kind closer_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            CH_CLOSE_ROUND:  k = KIND_ROUND;
            CH_CLOSE_SQUARE: k = KIND_SQUARE;
            CH_CLOSE_CURLY:  k = KIND_CURLY;
            default:         k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/bbc_ram.sv @@
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bbc_stack_ctrl.sv @@
module bbc_stack_ctrl
    import bbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_in               i_in,
    output t_out              o_res,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [1:0]        o_wdata,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [1:0]        i_rdata
);

    // top of stack and the entry below it live in registers, the rest in ram
    logic [CNT_W-1:0] r_count, n_count;
    t_err             r_err, n_err;
    t_kind            r_top, n_top;
    t_kind            r_below, n_below;
    logic             r_below_mem, n_below_mem;

    t_kind            open_k, close_k, below;
    logic             active, push, ovf, pop, mis;
    logic [CNT_W-1:0] upd_count;
    t_err             upd_err;

    assign open_k  = opener_kind(i_in.char_in);
    assign close_k = closer_kind(i_in.char_in);
    assign below   = r_below_mem ? t_kind'(i_rdata) : r_below;

    assign active = i_fire && (r_err == ERR_OK);
    assign push   = active && (open_k != KIND_NONE) && (r_count < CNT_W'(STACK_DEPTH));
    assign ovf    = active && (open_k != KIND_NONE) && !(r_count < CNT_W'(STACK_DEPTH));
    assign pop    = active && (open_k == KIND_NONE) && (close_k != KIND_NONE)
                    && (r_count != '0) && (r_top == close_k);
    assign mis    = active && (open_k == KIND_NONE) && (close_k != KIND_NONE) && !pop;

    always_comb begin
        upd_count = r_count;
        upd_err   = r_err;
        if (push) begin
            upd_count = r_count + CNT_W'(1);
        end else if (pop) begin
            upd_count = r_count - CNT_W'(1);
        end
        if (ovf) begin
            upd_err = ERR_OVERFLOW;
        end else if (mis) begin
            upd_err = ERR_MATCH;
        end
    end

    always_comb begin
        o_res.done_res = i_in.is_last;
        o_res.balanced = i_in.is_last && (upd_err == ERR_OK) && (upd_count == '0);
        o_res.status   = upd_err;
        if (upd_count > CNT_W'(DEPTH_SAT)) begin
            o_res.open_depth = DEPTH_W'(DEPTH_SAT);
        end else begin
            o_res.open_depth = DEPTH_W'(upd_count);
        end
    end

    // old top spills to ram on push; entry two below the top is fetched ahead of a pop
    assign o_we    = push && (r_count != '0);
    assign o_waddr = ADDR_W'(r_count - CNT_W'(1));
    assign o_wdata = r_top;
    assign o_raddr = ADDR_W'(r_count - CNT_W'(3));

    always_comb begin
        n_count     = upd_count;
        n_err       = upd_err;
        n_top       = r_top;
        n_below     = below;
        n_below_mem = 1'b0;
        if (push) begin
            n_top   = open_k;
            n_below = r_top;
        end else if (pop) begin
            n_top       = below;
            n_below_mem = 1'b1;
        end
        if (i_fire && i_in.is_last) begin
            n_count = '0;
            n_err   = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ERR_OK;
            r_below_mem <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_err       <= n_err;
            r_below_mem <= n_below_mem;
        end
        r_top   <= n_top;
        r_below <= n_below;
    end

endmodule

@@ rtl/bracket_balance_checker.sv @@
// output: the result of a byte is registered and presented in the cycle after its transaction is taken
// throughput: one byte per cycle, sustained while the output is not stalled, including runs of pushes and pops
// stack top and the entry below it are registers, deeper entries sit in a one-port-each
// ram with a registered read, prefetched one pop ahead
// reset: synchronous active low, clears count, sticky error and output valid; ram not cleared
module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic              fire;
    t_out              res;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [1:0]        wdata, rdata;

    logic r_valid;
    t_out r_out;

    assign o_in_ready = !r_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    bbc_stack_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_in    (i_in_data),
        .o_res   (res),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/bbc_checker.sv @@
module bbc_checker
    import bbc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction dropped or changed while stalled");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted byte produced no result");

    a_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.balanced |->
            o_out_data.done_res && (o_out_data.status == ERR_OK)
            && (o_out_data.open_depth == '0))
        else $error("balanced flagged without clean empty end");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ERR_OK) || (o_out_data.status == ERR_MATCH)
            || (o_out_data.status == ERR_OVERFLOW))
        else $error("illegal status code");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.open_depth <= DEPTH_W'(STACK_DEPTH > DEPTH_SAT ?
            DEPTH_SAT : STACK_DEPTH)))
        else $error("open depth beyond stack size");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);
